// File: rtl/core/pwmdc_pkg.sv
package pwmdc_pkg;

  // Field widths
  localparam int unsigned RATE_W  = 30;
  localparam int unsigned NS_W    = 31;
  localparam int unsigned EXP_W   = 4;
  localparam int unsigned PRE_W   = 8;
  localparam int unsigned FIELD_W = 16;

  // Internal widths: tick count and the shared divider word
  localparam int unsigned TICK_W = 32;
  localparam int unsigned WORD_W = 64;

  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(24000000);
  localparam logic [WORD_W-1:0]  NS_PER_S   = WORD_W'(1000000000);
  localparam logic [WORD_W-1:0]  NS_HALF    = WORD_W'(500000000);
  localparam logic [FIELD_W-1:0] FIELD_MAX  = '1;

  // Parameter defaults
  localparam int unsigned COUNT_BITS_DEF     = 16;
  localparam int unsigned MAX_DIV_EXP_DEF    = 8;
  localparam int unsigned PRESCALE_STEPS_DEF = 256;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_TICKS,
    OP_DIV_TICKS,
    OP_TICKS_DONE,
    OP_EXP_STEP,
    OP_NO_FIT,
    OP_DIV_PRE,
    OP_PRE_DONE,
    OP_DIV_WHOLE,
    OP_WHOLE_DONE,
    OP_MUL_ACT,
    OP_DIV_ACT,
    OP_ACT_DONE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic fit;
    logic exp_last;
    logic period_zero;
  } dp_sts_t;

endpackage

// File: rtl/core/pwm_divider_and_count_calc.sv
// Sequencing: each accepted word goes through the tick division, the exponent walk,
//   the prescale division (when an exponent fits), the whole division and, for a
//   nonzero period, the active-count division; an output stall holds its result.
// Flow: one word at a time; the next word is taken in the cycle after the result
//   is published; each word uses the 64-step serial divider up to four times.
// Reset (synchronous, rst_n low): controller idle, no result pending,
//   clock rate register back to 24 MHz.
module pwm_divider_and_count_calc #(
  parameter int unsigned COUNT_BITS     = pwmdc_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_DIV_EXP    = pwmdc_pkg::MAX_DIV_EXP_DEF,
  parameter int unsigned PRESCALE_STEPS = pwmdc_pkg::PRESCALE_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: input clock rate in hertz
  input  logic                              cfg_wr_en,
  input  logic [pwmdc_pkg::RATE_W-1:0]      cfg_wr_data,
  // request word
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pwmdc_pkg::NS_W-1:0]        in_period_ns,
  input  logic [pwmdc_pkg::NS_W-1:0]        in_duty_ns,
  input  logic                              in_polarity,
  // result word
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwmdc_pkg::EXP_W-1:0]       out_divider_exponent,
  output logic [pwmdc_pkg::PRE_W-1:0]       out_prescaler,
  output logic [pwmdc_pkg::FIELD_W-1:0]     out_cycle_field,
  output logic [pwmdc_pkg::FIELD_W-1:0]     out_active_count,
  output logic                              out_active_high,
  output logic                              out_out_of_range
);
  import pwmdc_pkg::*;

  // Sequence per word:
  //   ticks    = round(rate * period / 1e9), at least 2
  //   exponent = first e whose bound (2^COUNT_BITS + 1) * steps * 2^e exceeds ticks,
  //              walked one exponent per cycle
  //   prescale = ticks / ((2^COUNT_BITS + 1) * 2^e), or the largest divisor if none fit
  //   whole    = ticks / (2^e * (prescale + 1)), at least 1
  //   active   = round(whole * duty / period), clamped; all ones for a zero period
  // The result sits in an output register, so a new word is taken while it waits.

  dp_cmd_t cmd;
  dp_sts_t sts;

  pwmdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  pwmdc_dp #(
    .COUNT_BITS     (COUNT_BITS),
    .MAX_DIV_EXP    (MAX_DIV_EXP),
    .PRESCALE_STEPS (PRESCALE_STEPS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_period_ns         (in_period_ns),
    .in_duty_ns           (in_duty_ns),
    .in_polarity          (in_polarity),
    .out_divider_exponent (out_divider_exponent),
    .out_prescaler        (out_prescaler),
    .out_cycle_field      (out_cycle_field),
    .out_active_count     (out_active_count),
    .out_active_high      (out_active_high),
    .out_out_of_range     (out_out_of_range)
  );

endmodule

// File: rtl/core/pwmdc_div.sv
module pwmdc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic [pwmdc_pkg::WORD_W-1:0]     dividend_i,
  input  logic [pwmdc_pkg::WORD_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [pwmdc_pkg::WORD_W-1:0]     quotient_o
);
  import pwmdc_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] den_r;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;
  logic [WORD_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});
  assign rem_nxt = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      den_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[WORD_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

// File: rtl/core/pwmdc_dp.sv
module pwmdc_dp #(
  parameter int unsigned COUNT_BITS     = pwmdc_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_DIV_EXP    = pwmdc_pkg::MAX_DIV_EXP_DEF,
  parameter int unsigned PRESCALE_STEPS = pwmdc_pkg::PRESCALE_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pwmdc_pkg::dp_cmd_t                cmd_i,
  output pwmdc_pkg::dp_sts_t                sts_o,
  input  logic                              cfg_wr_en,
  input  logic [pwmdc_pkg::RATE_W-1:0]      cfg_wr_data,
  input  logic [pwmdc_pkg::NS_W-1:0]        in_period_ns,
  input  logic [pwmdc_pkg::NS_W-1:0]        in_duty_ns,
  input  logic                              in_polarity,
  output logic [pwmdc_pkg::EXP_W-1:0]       out_divider_exponent,
  output logic [pwmdc_pkg::PRE_W-1:0]       out_prescaler,
  output logic [pwmdc_pkg::FIELD_W-1:0]     out_cycle_field,
  output logic [pwmdc_pkg::FIELD_W-1:0]     out_active_count,
  output logic                              out_active_high,
  output logic                              out_out_of_range
);
  import pwmdc_pkg::*;

  // Tick bound for the first exponent: (2^COUNT_BITS + 1) * steps
  localparam logic [WORD_W-1:0] LIMIT_P1 = (WORD_W'(1) << COUNT_BITS) + WORD_W'(1);
  localparam logic [WORD_W-1:0] BOUND0   = LIMIT_P1 * WORD_W'(PRESCALE_STEPS);
  localparam logic [EXP_W-1:0]  EXP_MAX  = EXP_W'(MAX_DIV_EXP);
  localparam logic [PRE_W-1:0]  PRE_MAX  = PRE_W'(PRESCALE_STEPS - 1);

  logic [RATE_W-1:0]       clock_rate_r;
  logic [NS_W-1:0]         period_r;
  logic [NS_W-1:0]         duty_r;
  logic                    pol_r;
  logic [WORD_W-1:0]       prod_r;
  logic [TICK_W-1:0]       ticks_r;
  logic [WORD_W-1:0]       bound_r;
  logic [WORD_W-1:0]       kdiv_r;
  logic [EXP_W-1:0]        exp_r;
  logic [PRE_W-1:0]        pre_r;
  logic [TICK_W-1:0]       whole_r;
  logic [FIELD_W-1:0]      act_r;

  logic [TICK_W-1:0]       mul_a;
  logic [NS_W-1:0]         mul_b;
  logic [TICK_W+NS_W-1:0]  mul_p;

  logic                    div_start;
  logic [WORD_W-1:0]       div_dividend;
  logic [WORD_W-1:0]       div_divisor;
  logic                    div_done;
  logic [WORD_W-1:0]       div_q;

  logic [TICK_W-1:0]       tick_q;
  logic [TICK_W-1:0]       cyc_full;

  // Shared multiplier: rate * period for the tick count, whole * duty for the active count
  assign mul_a = (cmd_i.op == OP_MUL_TICKS) ? TICK_W'(clock_rate_r) : whole_r;
  assign mul_b = (cmd_i.op == OP_MUL_TICKS) ? period_r : duty_r;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_r + NS_HALF;
    div_divisor  = NS_PER_S;
    unique case (cmd_i.op)
      OP_DIV_TICKS: begin
        div_start = 1'b1;
      end
      OP_DIV_PRE: begin
        div_start    = 1'b1;
        div_dividend = WORD_W'(ticks_r);
        div_divisor  = kdiv_r;
      end
      OP_DIV_WHOLE: begin
        div_start    = 1'b1;
        div_dividend = WORD_W'(ticks_r);
        div_divisor  = WORD_W'({1'b0, pre_r} + (PRE_W + 1)'(1)) << exp_r;
      end
      OP_DIV_ACT: begin
        div_start    = 1'b1;
        div_dividend = prod_r + WORD_W'(period_r >> 1);
        div_divisor  = WORD_W'(period_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pwmdc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign tick_q   = div_q[TICK_W-1:0];
  assign cyc_full = whole_r - TICK_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= RATE_RESET;
    end else if (cfg_wr_en) begin
      clock_rate_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        period_r <= in_period_ns;
        duty_r   <= in_duty_ns;
        pol_r    <= in_polarity;
      end
      OP_MUL_TICKS, OP_MUL_ACT: begin
        prod_r <= WORD_W'(mul_p);
      end
      OP_TICKS_DONE: begin
        ticks_r <= (tick_q < TICK_W'(2)) ? TICK_W'(2) : tick_q;
        exp_r   <= '0;
        bound_r <= BOUND0;
        kdiv_r  <= LIMIT_P1;
      end
      OP_EXP_STEP: begin
        exp_r   <= exp_r + EXP_W'(1);
        bound_r <= bound_r << 1;
        kdiv_r  <= kdiv_r << 1;
      end
      OP_NO_FIT: begin
        pre_r <= PRE_MAX;
      end
      OP_PRE_DONE: begin
        pre_r <= div_q[PRE_W-1:0];
      end
      OP_WHOLE_DONE: begin
        whole_r <= (div_q == '0) ? TICK_W'(1) : tick_q;
        act_r   <= FIELD_MAX;
      end
      OP_ACT_DONE: begin
        act_r <= (div_q > WORD_W'(FIELD_MAX)) ? FIELD_MAX : div_q[FIELD_W-1:0];
      end
      OP_PUBLISH: begin
        out_divider_exponent <= exp_r;
        out_prescaler        <= pre_r;
        out_active_count     <= act_r;
        out_active_high      <= pol_r;
        if (cyc_full > TICK_W'(FIELD_MAX)) begin
          out_cycle_field  <= FIELD_MAX;
          out_out_of_range <= 1'b1;
        end else begin
          out_cycle_field  <= cyc_full[FIELD_W-1:0];
          out_out_of_range <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.div_done    = div_done;
  assign sts_o.fit         = (WORD_W'(ticks_r) < bound_r);
  assign sts_o.exp_last    = (exp_r == EXP_MAX);
  assign sts_o.period_zero = (period_r == '0);

endmodule

// File: rtl/core/pwmdc_ctrl.sv
module pwmdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pwmdc_pkg::dp_cmd_t  cmd_o,
  input  pwmdc_pkg::dp_sts_t  sts_i
);
  import pwmdc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_DIV_T,
    ST_WAIT_T,
    ST_EXP,
    ST_DIV_P,
    ST_WAIT_P,
    ST_DIV_W,
    ST_WAIT_W,
    ST_MUL_A,
    ST_DIV_A,
    ST_WAIT_A,
    ST_PUB
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  dp_op_t op;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_MUL_T;
        end
      end
      ST_MUL_T: begin
        op        = OP_MUL_TICKS;
        state_nxt = ST_DIV_T;
      end
      ST_DIV_T: begin
        op        = OP_DIV_TICKS;
        state_nxt = ST_WAIT_T;
      end
      ST_WAIT_T: begin
        if (sts_i.div_done) begin
          op        = OP_TICKS_DONE;
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        priority if (sts_i.fit) begin
          state_nxt = ST_DIV_P;
        end else if (sts_i.exp_last) begin
          op        = OP_NO_FIT;
          state_nxt = ST_DIV_W;
        end else begin
          op = OP_EXP_STEP;
        end
      end
      ST_DIV_P: begin
        op        = OP_DIV_PRE;
        state_nxt = ST_WAIT_P;
      end
      ST_WAIT_P: begin
        if (sts_i.div_done) begin
          op        = OP_PRE_DONE;
          state_nxt = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        op        = OP_DIV_WHOLE;
        state_nxt = ST_WAIT_W;
      end
      ST_WAIT_W: begin
        if (sts_i.div_done) begin
          op        = OP_WHOLE_DONE;
          state_nxt = sts_i.period_zero ? ST_PUB : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        op        = OP_MUL_ACT;
        state_nxt = ST_DIV_A;
      end
      ST_DIV_A: begin
        op        = OP_DIV_ACT;
        state_nxt = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (sts_i.div_done) begin
          op        = OP_ACT_DONE;
          state_nxt = ST_PUB;
        end
      end
      ST_PUB: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          op        = OP_PUBLISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (op == OP_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign cmd_o.op  = op;

endmodule
